### rtl/core/pipd_pkg.sv
package pipd_pkg;

   // Channel widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 64;
   localparam int KIND_W      = 2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PIXEL      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PALETTE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_HEADER = 2'd2;

   // Header layout
   localparam logic [7:0] FLAG_RAW        = 8'h00;
   localparam logic [7:0] FLAG_COMPRESSED = 8'h80;
   localparam logic [7:0] RES_MAX         = 8'd2;
   localparam logic [5:0] HEADER_BYTES    = 6'd34;

   // Resolution codes
   localparam logic [1:0] RES_LOW  = 2'd0;
   localparam logic [1:0] RES_MED  = 2'd1;
   localparam logic [1:0] RES_MONO = 2'd2;

   // PackBits repeat count base (257 - control)
   localparam logic [8:0] REPEAT_BASE = 9'h101;

   localparam int LINE_LO      = 40;
   localparam int LINE_HI      = 80;
   localparam int ROWS_LO      = 200;
   localparam int ROWS_HI      = 400;
   localparam int PLANE_LO     = LINE_LO * ROWS_LO;
   localparam int PLANE_MED    = LINE_HI * ROWS_LO;
   localparam int PLANE_MONO   = LINE_HI * ROWS_HI;

   function automatic logic [7:0] line_bytes(input logic [1:0] res);
      return (res == RES_LOW) ? 8'(LINE_LO) : 8'(LINE_HI);
   endfunction

   function automatic logic [8:0] image_rows(input logic [1:0] res);
      return (res == RES_MONO) ? 9'(ROWS_HI) : 9'(ROWS_LO);
   endfunction

   function automatic logic [2:0] plane_count(input logic [1:0] res);
      logic [2:0] n;
      case (res)
         RES_LOW: n = 3'd4;
         RES_MED: n = 3'd2;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   // Start offset of a plane, modulo the 15-bit buffer space
   function automatic logic [14:0] plane_base(input logic [1:0] res, input logic [1:0] pl);
      logic [16:0] prod;
      case (res)
         RES_LOW: prod = 17'(pl) * 17'(PLANE_LO);
         RES_MED: prod = 17'(pl) * 17'(PLANE_MED);
         default: prod = 17'(pl) * 17'(PLANE_MONO);
      endcase
      return prod[14:0];
   endfunction

   // Start offset of a row inside its plane, modulo the buffer space
   function automatic logic [14:0] row_base(input logic [1:0] res, input logic [8:0] rw);
      logic [16:0] prod;
      if (res == RES_LOW) begin
         prod = 17'(rw) * 17'(LINE_LO);
      end else begin
         prod = 17'(rw) * 17'(LINE_HI);
      end
      return prod[14:0];
   endfunction

endpackage

### rtl/core/planar_image_packbits_decoder_unit.sv
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: data_byte; tuser: file_start
// rsp      out  rsp_tvalid/rsp_tready  tdata: pixel/palette fields; tuser: kind; tlast: done
//
// Takes one word per cycle unless rsp stalls; its result, if any, shows on rsp in the
// cycle after acceptance. The rate is set by the single result register: a new word
// enters whenever that register is empty or being drained in the same cycle.
// Reset is synchronous, active high; it clears all decoder state and the result valid.
// A stall on rsp holds the result and stops intake until the result is taken.
module planar_image_packbits_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pipd_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] data_byte
   input  logic                               req_tuser,  // [0] file_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [14:0] address, [22:15] value, [30:23] run_length, [34:31] colour_index,
   // [42:35] red, [50:43] green, [58:51] blue, [63:59] zero
   output logic [pipd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [pipd_pkg::KIND_W-1:0]        rsp_tuser,  // [1:0] kind
   output logic                               rsp_tlast   // image_done
);
   import pipd_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_RAW,
      PH_CTRL,
      PH_REPEAT,
      PH_LITERAL,
      PH_IDLE
   } phase_type;

   // Decoder state
   phase_type   phase_ff,     phase_in;
   logic [5:0]  hdr_pos_ff,   hdr_pos_in;
   logic        comp_ff,      comp_in;
   logic [1:0]  res_ff,       res_in;
   logic [8:0]  row_ff,       row_in;
   logic [1:0]  plane_ff,     plane_in;
   logic [7:0]  column_ff,    column_in;
   logic [7:0]  lit_left_ff,  lit_left_in;
   logic [7:0]  rep_count_ff, rep_count_in;
   logic [7:0]  pal_high_ff,  pal_high_in;
   logic        word_half_ff, word_half_in;
   logic [14:0] wr_ptr_ff,    wr_ptr_in;

   // Result register
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff,   kind_in;
   logic [14:0] addr_ff,   addr_in;
   logic [7:0]  value_ff,  value_in;
   logic [7:0]  run_ff,    run_in;
   logic [3:0]  cidx_ff,   cidx_in;
   logic [7:0]  red_ff,    red_in;
   logic [7:0]  green_ff,  green_in;
   logic [7:0]  blue_ff,   blue_in;
   logic        done_ff,   done_in;
   logic        emit;

   // State as seen by the accepted word: file_start drops all progress first
   phase_type   cur_phase;
   logic [5:0]  cur_pos;
   logic        cur_comp;
   logic [1:0]  cur_res;
   logic [8:0]  cur_row;
   logic [1:0]  cur_plane;
   logic [7:0]  cur_column;
   logic [7:0]  cur_lit;
   logic [7:0]  cur_rep;
   logic [7:0]  cur_pal;
   logic        cur_wh;
   logic [14:0] cur_ptr;

   // Line-end bookkeeping shared by repeat and literal packets
   logic [7:0]  fin_col;
   logic        fin_full;
   logic [1:0]  fin_plane;
   logic [8:0]  fin_row;
   logic        fin_done;
   logic [14:0] fin_ptr;

   logic        accept;
   logic [7:0]  d;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign d          = req_tdata[7:0];

   always_comb begin
      if (req_tuser) begin
         cur_phase  = PH_HEADER;
         cur_pos    = '0;
         cur_comp   = 1'b0;
         cur_res    = '0;
         cur_row    = '0;
         cur_plane  = '0;
         cur_column = '0;
         cur_lit    = '0;
         cur_rep    = '0;
         cur_pal    = '0;
         cur_wh     = 1'b0;
         cur_ptr    = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = hdr_pos_ff;
         cur_comp   = comp_ff;
         cur_res    = res_ff;
         cur_row    = row_ff;
         cur_plane  = plane_ff;
         cur_column = column_ff;
         cur_lit    = lit_left_ff;
         cur_rep    = rep_count_ff;
         cur_pal    = pal_high_ff;
         cur_wh     = word_half_ff;
         cur_ptr    = wr_ptr_ff;
      end
   end

   // Advance to the next plane or row once a packet fills the line
   always_comb begin
      logic [2:0] pl_nx;
      logic       wrap;
      if (cur_phase == PH_REPEAT) begin
         fin_col = cur_column + cur_rep;
      end else begin
         fin_col = cur_column + 8'd1;
      end
      fin_full  = fin_col >= line_bytes(cur_res);
      pl_nx     = {1'b0, cur_plane} + 3'd1;
      wrap      = pl_nx >= plane_count(cur_res);
      fin_plane = wrap ? 2'd0 : pl_nx[1:0];
      fin_row   = wrap ? cur_row + 9'd1 : cur_row;
      fin_done  = fin_full && (fin_row >= image_rows(cur_res));
      fin_ptr   = plane_base(cur_res, fin_plane) + row_base(cur_res, fin_row);
   end

   always_comb begin
      logic [2:0] pl_nx;
      logic [7:0] col_nx;
      logic [8:0] row_nx;
      logic [5:0] pos_nx;
      logic [7:0] lit_dec;
      logic [7:0] mono;
      logic [3:0] idx;

      phase_in     = cur_phase;
      hdr_pos_in   = cur_pos;
      comp_in      = cur_comp;
      res_in       = cur_res;
      row_in       = cur_row;
      plane_in     = cur_plane;
      column_in    = cur_column;
      lit_left_in  = cur_lit;
      rep_count_in = cur_rep;
      pal_high_in  = cur_pal;
      word_half_in = cur_wh;
      wr_ptr_in    = cur_ptr;

      emit     = 1'b0;
      kind_in  = KIND_PIXEL;
      addr_in  = '0;
      value_in = '0;
      run_in   = '0;
      cidx_in  = '0;
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      done_in  = 1'b0;

      pl_nx   = {1'b0, cur_plane} + 3'd1;
      col_nx  = cur_column + 8'd2;
      row_nx  = cur_row + 9'd1;
      pos_nx  = cur_pos + 6'd1;
      lit_dec = (cur_lit != 8'd0) ? cur_lit - 8'd1 : 8'd0;
      idx     = 4'((cur_pos - 6'd2) >> 1);
      mono    = (idx == 4'd0) ? 8'hFF : 8'h00;

      case (cur_phase)
         PH_HEADER: begin
            if (cur_pos == 6'd0) begin
               if (d != FLAG_RAW && d != FLAG_COMPRESSED) begin
                  emit     = 1'b1;
                  kind_in  = KIND_BAD_HEADER;
                  phase_in = PH_IDLE;
               end else begin
                  comp_in    = d[7];
                  hdr_pos_in = 6'd1;
               end
            end else if (cur_pos == 6'd1) begin
               if (d > RES_MAX) begin
                  emit     = 1'b1;
                  kind_in  = KIND_BAD_HEADER;
                  phase_in = PH_IDLE;
               end else begin
                  res_in     = d[1:0];
                  hdr_pos_in = 6'd2;
               end
            end else begin
               // Palette words: high byte on even offsets, low byte completes the entry
               if (!cur_pos[0]) begin
                  pal_high_in = d;
               end else if (cur_res == RES_MONO) begin
                  if (idx < 4'd2) begin
                     emit     = 1'b1;
                     kind_in  = KIND_PALETTE;
                     cidx_in  = idx;
                     red_in   = mono;
                     green_in = mono;
                     blue_in  = mono;
                  end
               end else begin
                  emit     = 1'b1;
                  kind_in  = KIND_PALETTE;
                  cidx_in  = idx;
                  red_in   = {cur_pal[2:0], 5'd0};
                  green_in = {d[6:4], 5'd0};
                  blue_in  = {d[2:0], 5'd0};
               end
               hdr_pos_in = pos_nx;
               if (pos_nx >= HEADER_BYTES) begin
                  row_in       = '0;
                  plane_in     = '0;
                  column_in    = '0;
                  word_half_in = 1'b0;
                  wr_ptr_in    = '0;
                  lit_left_in  = '0;
                  rep_count_in = '0;
                  phase_in     = cur_comp ? PH_CTRL : PH_RAW;
               end
            end
         end

         PH_RAW: begin
            // Words interleave the planes: two bytes per plane, then the next plane
            emit     = 1'b1;
            addr_in  = plane_base(cur_res, cur_plane) + row_base(cur_res, cur_row)
                       + 15'(cur_column) + 15'(cur_wh);
            value_in = d;
            run_in   = 8'd1;
            if (!cur_wh) begin
               word_half_in = 1'b1;
            end else begin
               word_half_in = 1'b0;
               if (pl_nx >= plane_count(cur_res)) begin
                  plane_in = '0;
                  if (col_nx >= line_bytes(cur_res)) begin
                     column_in = '0;
                     row_in    = row_nx;
                     if (row_nx >= image_rows(cur_res)) begin
                        phase_in = PH_IDLE;
                        done_in  = 1'b1;
                     end
                  end else begin
                     column_in = col_nx;
                  end
               end else begin
                  plane_in = pl_nx[1:0];
               end
            end
         end

         PH_CTRL: begin
            if (d[7]) begin
               rep_count_in = 8'(REPEAT_BASE - {1'b0, d});
               phase_in     = PH_REPEAT;
            end else begin
               lit_left_in = d + 8'd1;
               phase_in    = PH_LITERAL;
            end
         end

         PH_REPEAT: begin
            emit      = 1'b1;
            addr_in   = cur_ptr;
            value_in  = d;
            run_in    = cur_rep;
            wr_ptr_in = cur_ptr + 15'(cur_rep);
            column_in = fin_col;
            phase_in  = PH_CTRL;
            if (fin_full) begin
               column_in = '0;
               plane_in  = fin_plane;
               row_in    = fin_row;
               if (fin_done) begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end else begin
                  wr_ptr_in = fin_ptr;
               end
            end
         end

         PH_LITERAL: begin
            emit        = 1'b1;
            addr_in     = cur_ptr;
            value_in    = d;
            run_in      = 8'd1;
            wr_ptr_in   = cur_ptr + 15'd1;
            column_in   = fin_col;
            lit_left_in = lit_dec;
            if (lit_dec == 8'd0) begin
               phase_in = PH_CTRL;
               if (fin_full) begin
                  column_in = '0;
                  plane_in  = fin_plane;
                  row_in    = fin_row;
                  if (fin_done) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     wr_ptr_in = fin_ptr;
                  end
               end
            end
         end

         default: begin
            // Idle: drop words until the next file start
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_pos_ff   <= '0;
         comp_ff      <= 1'b0;
         res_ff       <= '0;
         row_ff       <= '0;
         plane_ff     <= '0;
         column_ff    <= '0;
         lit_left_ff  <= '0;
         rep_count_ff <= '0;
         pal_high_ff  <= '0;
         word_half_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            hdr_pos_ff   <= hdr_pos_in;
            comp_ff      <= comp_in;
            res_ff       <= res_in;
            row_ff       <= row_in;
            plane_ff     <= plane_in;
            column_ff    <= column_in;
            lit_left_ff  <= lit_left_in;
            rep_count_ff <= rep_count_in;
            pal_high_ff  <= pal_high_in;
            word_half_ff <= word_half_in;
            wr_ptr_ff    <= wr_ptr_in;
            rsp_valid_ff <= emit;
            if (emit) begin
               kind_ff  <= kind_in;
               addr_ff  <= addr_in;
               value_ff <= value_in;
               run_ff   <= run_in;
               cidx_ff  <= cidx_in;
               red_ff   <= red_in;
               green_ff <= green_in;
               blue_ff  <= blue_in;
               done_ff  <= done_in;
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {5'd0, blue_ff, green_ff, red_ff, cidx_ff, run_ff, value_ff, addr_ff};

`ifndef NO_ASSERTIONS
   // Never take a word while a held result would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(accept && rsp_valid_ff && !rsp_tready))
      else $error("word accepted over a stalled result");

   // Pixel writes always cover at least one byte
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_PIXEL) |-> (rsp_tdata[30:23] != 8'd0))
      else $error("pixel write with zero run length");

   // Only pixel writes may close the image
   a_done_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_PIXEL))
      else $error("image done on a non-pixel result");

   // A literal packet in progress has bytes left
   a_literal_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LITERAL) |-> (lit_left_ff != 8'd0))
      else $error("literal phase with no bytes left");

   // Between packets the line position stays inside the line
   a_ctrl_column: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CTRL) |-> (column_ff < line_bytes(res_ff)))
      else $error("control byte expected past line end");
`endif

endmodule
